[hdl/sha256_folded_digest_top_macros.svh]
// assertion macros shared by the design files
`ifndef SHA256_FOLDED_DIGEST_TOP_MACROS_SVH
`define SHA256_FOLDED_DIGEST_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sfd_pkg.sv]
package sfd_pkg;

  typedef logic [31:0] word_t;

  localparam logic [5:0] OUT_MAX  = 6'd32;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam word_t IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // sequencer to compression core
  typedef struct packed {
    logic       push;
    word_t      word;
    logic       start;
    logic       init;
    logic [4:0] rd_idx;
  } sfd_core_cmd_t;

  // compression core to sequencer
  typedef struct packed {
    logic       busy;
    logic [7:0] rd_byte;
  } sfd_core_sts_t;

endpackage

[hdl/sfd_in_if.sv]
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last,
                output ready);
endinterface

[hdl/sfd_out_if.sv]
interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic [4:0] byte_index;
  logic       last_byte;

  modport source (output valid, output digest_byte, output byte_index,
                  output last_byte, input ready);
  modport sink (input valid, input digest_byte, input byte_index,
                input last_byte, output ready);
endinterface

[hdl/sfd_round.sv]
module sfd_round
  import sfd_pkg::*;
(
  input  word_t v_i [8],
  input  word_t k_i,
  input  logic  sched_sel,
  input  word_t x0,
  input  word_t x1,
  input  word_t x9,
  input  word_t x14,
  output word_t v_o [8],
  output word_t w_o
);

  function automatic word_t rotr(word_t x, int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  word_t ss0, ss1, bs0, bs1, ch, maj, t1, t2;

  always_comb begin
    ss0 = rotr(x1, 7) ^ rotr(x1, 18) ^ (x1 >> 3);
    ss1 = rotr(x14, 17) ^ rotr(x14, 19) ^ (x14 >> 10);
    w_o = sched_sel ? (x0 + ss0 + ss1 + x9) : x0;

    bs1 = rotr(v_i[4], 6) ^ rotr(v_i[4], 11) ^ rotr(v_i[4], 25);
    ch  = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    bs0 = rotr(v_i[0], 2) ^ rotr(v_i[0], 13) ^ rotr(v_i[0], 22);
    maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1  = v_i[7] + bs1 + ch + k_i + w_o;
    t2  = bs0 + maj;

    v_o[0] = t1 + t2;
    v_o[1] = v_i[0];
    v_o[2] = v_i[1];
    v_o[3] = v_i[2];
    v_o[4] = v_i[3] + t1;
    v_o[5] = v_i[4];
    v_o[6] = v_i[5];
    v_o[7] = v_i[6];
  end

endmodule

[hdl/sfd_core.sv]
`include "sha256_folded_digest_top_macros.svh"

module sfd_core
  import sfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  sfd_core_cmd_t cmd,
  output sfd_core_sts_t sts
);

  word_t      h_r [8];
  word_t      v_r [8];
  word_t      s_r [16];
  word_t      v_new [8];
  word_t      w_new;
  word_t      h_sel;
  logic [5:0] rnd_r;
  logic       busy_r;
  logic       ff_r;

  sfd_round u_round (
    .v_i       (v_r),
    .k_i       (K_TAB[rnd_r]),
    .sched_sel (rnd_r[5:4] != 2'b00),
    .x0        (s_r[0]),
    .x1        (s_r[1]),
    .x9        (s_r[9]),
    .x14       (s_r[14]),
    .v_o       (v_new),
    .w_o       (w_new)
  );

  // round counter and feed-forward cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ff_r   <= 1'b0;
      rnd_r  <= '0;
    end else begin
      ff_r <= busy_r && (rnd_r == LAST_POS);
      if (cmd.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == LAST_POS) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // chaining hash
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
    end else if (cmd.init) begin
      for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
    end else if (ff_r) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  // working variables and schedule line
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      v_r <= h_r;
    end else if (busy_r) begin
      v_r <= v_new;
    end
    if (cmd.push || busy_r) begin
      for (int i = 0; i < 15; i++) s_r[i] <= s_r[i + 1];
      s_r[15] <= cmd.push ? cmd.word : w_new;
    end
  end

  always_comb begin
    h_sel       = h_r[cmd.rd_idx[4:2]];
    sts.busy    = busy_r || ff_r;
    sts.rd_byte = h_sel[{~cmd.rd_idx[1:0], 3'b000} +: 8];
  end

  `SFD_ASSERT_NEXT(a_start_runs, cmd.start, busy_r && rnd_r == 6'd0, "round run did not start")
  `SFD_ASSERT_NOW(a_cmd_idle, cmd.push || cmd.start, !busy_r && !ff_r, "word or start while busy")
  `SFD_ASSERT_NEXT(a_ff_follows, busy_r && rnd_r == LAST_POS, ff_r && !busy_r, "no feed-forward")

endmodule

[hdl/sha256_folded_digest_top.sv]
// channel   | dir | payload                                | request moves
// ----------+-----+----------------------------------------+-----------------------
// in_ch     | in  | data_byte[7:0], has_byte, last         | one message byte / end
// out_ch    | out | digest_byte[7:0], byte_index[4:0],     | one folded digest byte
//           |     | last_byte                              |
// cfg       | in  | cfg_we, cfg_wdata[5:0]                 | out_length write
//
// a byte request is taken in idle; the 64th byte of a block starts 64 rounds in
// the shared round unit, then the feed-forward add and the return to idle
// a last request adds the padding bytes, one or two block compressions, and one
// fold pass over the digest for each folded output byte
// out_ch has an output register; a stalled out_ch holds the folding sequencer
// reset: hash to initial values, out_length to 32, no clearing pass
`include "sha256_folded_digest_top_macros.svh"

module sha256_folded_digest_top
  import sfd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  sfd_in_if.sink          in_ch,
  sfd_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [5:0]      cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_FOLD = 2'd3;

  sfd_core_cmd_t cmd;
  sfd_core_sts_t sts;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [23:0] pack_r, pack_nxt;
  logic [63:0] blen_r, blen_nxt;
  logic        pad_act_r, pad_act_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_phase_r, len_phase_nxt;
  logic        pad_done_r, pad_done_nxt;
  logic [4:0]  fold_j_r, fold_j_nxt;
  logic [5:0]  fold_k_r, fold_k_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [5:0]  out_len_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r;
  logic [4:0]  out_idx_r;
  logic        out_last_r;

  logic        in_fire;
  logic        push_en;
  logic [7:0]  push_val;
  logic        block_full;
  logic        len_eff;
  logic [7:0]  len_byte;
  logic [5:0]  n_eff;
  logic [5:0]  n_m1;
  logic        out_free;
  logic        fold_load;
  logic        fold_end;

  sfd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_byte = out_data_r;
  assign out_ch.byte_index  = out_idx_r;
  assign out_ch.last_byte   = out_last_r;

  always_comb begin
    in_fire  = in_ch.valid && in_ch.ready;
    len_eff  = len_phase_r || (fill_r == LEN_POS);
    len_byte = blen_r[{~fill_r[2:0], 3'b000} +: 8];

    if (out_len_r == 6'd0) begin
      n_eff = 6'd1;
    end else if (out_len_r > OUT_MAX) begin
      n_eff = OUT_MAX;
    end else begin
      n_eff = out_len_r;
    end
    n_m1 = n_eff - 6'd1;

    push_en  = 1'b0;
    push_val = in_ch.data_byte;
    case (state_r)
      ST_IDLE: begin
        push_en = in_fire && in_ch.has_byte;
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pad_first_r) begin
          push_val = PAD_BYTE;
        end else if (len_eff) begin
          push_val = len_byte;
        end else begin
          push_val = 8'h00;
        end
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
    block_full = push_en && (fill_r == LAST_POS);

    out_free  = !out_valid_r || out_ch.ready;
    fold_load = (state_r == ST_FOLD) && fold_k_r[5] && out_free;
    fold_end  = fold_load && ({1'b0, fold_j_r} == n_m1);

    cmd.push   = push_en && (fill_r[1:0] == 2'b11);
    cmd.word   = {pack_r, push_val};
    cmd.start  = block_full;
    cmd.init   = fold_end;
    cmd.rd_idx = fold_k_r[4:0];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = push_en ? fill_r + 6'd1 : fill_r;
    pack_nxt      = push_en ? {pack_r[15:0], push_val} : pack_r;
    blen_nxt      = blen_r;
    pad_act_nxt   = pad_act_r;
    pad_first_nxt = pad_first_r;
    len_phase_nxt = len_phase_r;
    pad_done_nxt  = pad_done_r;
    fold_j_nxt    = fold_j_r;
    fold_k_nxt    = fold_k_r;
    acc_nxt       = acc_r;
    out_valid_nxt = fold_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.has_byte) begin
            blen_nxt = blen_r + 64'd8;
          end
          if (in_ch.last) begin
            pad_act_nxt   = 1'b1;
            pad_first_nxt = 1'b1;
            len_phase_nxt = 1'b0;
            pad_done_nxt  = 1'b0;
          end
          if (block_full) begin
            state_nxt = ST_COMP;
          end else if (in_ch.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        pad_first_nxt = 1'b0;
        if (!pad_first_r && len_eff) begin
          len_phase_nxt = 1'b1;
        end
        if (block_full) begin
          state_nxt    = ST_COMP;
          pad_done_nxt = !pad_first_r && len_eff;
        end
      end
      ST_COMP: begin
        if (!sts.busy) begin
          if (pad_done_r) begin
            state_nxt  = ST_FOLD;
            fold_j_nxt = '0;
            fold_k_nxt = '0;
            acc_nxt    = '0;
          end else if (pad_act_r) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FOLD: begin
        if (!fold_k_r[5]) begin
          acc_nxt    = acc_r ^ sts.rd_byte;
          fold_k_nxt = fold_k_r + n_eff;
        end else if (out_free) begin
          if (fold_end) begin
            state_nxt    = ST_IDLE;
            blen_nxt     = '0;
            pad_act_nxt  = 1'b0;
            pad_done_nxt = 1'b0;
          end else begin
            fold_j_nxt = fold_j_r + 5'd1;
            fold_k_nxt = {1'b0, fold_j_r + 5'd1};
            acc_nxt    = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      blen_r      <= '0;
      pad_act_r   <= 1'b0;
      pad_first_r <= 1'b0;
      len_phase_r <= 1'b0;
      pad_done_r  <= 1'b0;
      fold_j_r    <= '0;
      fold_k_r    <= '0;
      out_valid_r <= 1'b0;
      out_len_r   <= OUT_MAX;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      blen_r      <= blen_nxt;
      pad_act_r   <= pad_act_nxt;
      pad_first_r <= pad_first_nxt;
      len_phase_r <= len_phase_nxt;
      pad_done_r  <= pad_done_nxt;
      fold_j_r    <= fold_j_nxt;
      fold_k_r    <= fold_k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        out_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pack_r <= pack_nxt;
    acc_r  <= acc_nxt;
    if (fold_load) begin
      out_data_r <= acc_r;
      out_idx_r  <= fold_j_r;
      out_last_r <= fold_end;
    end
  end

  `SFD_ASSERT_NOW(a_ready_core_idle, in_ch.ready, !sts.busy, "input ready while core busy")
  `SFD_ASSERT_NOW(a_end_on_boundary, cmd.init, fill_r == 6'd0, "digest out off block boundary")
  `SFD_ASSERT_NOW(a_last_index, out_valid_r, out_last_r == ({1'b0, out_idx_r} == n_m1), "bad last byte")

endmodule
